FILE: design/ccs_pkg.sv
// Shared constants and types for the chi-square contingency table block.
`timescale 1ns / 1ps

package ccs_pkg;

	localparam int MAX_ROWS = 16;
	localparam int MAX_COLS = 16;
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	// Shared unit widths: dividend/product, divisor, quotient, shifted operand.
	localparam int P_W = 112;
	localparam int D_W = 72;
	localparam int Q_W = 49;
	localparam int M_W = D_W + Q_W - 1;
	localparam int CNT_W = $clog2(Q_W);

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 5;
	localparam logic [CFG_IDX_W-1:0] CFG_NULL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd2;

	typedef struct packed {
		logic           start;
		logic           is_div;
		logic [P_W-1:0] opa;
		logic [D_W-1:0] opb;
	} mdu_cmd_t;

	typedef struct packed {
		logic           done;
		logic [P_W-1:0] p;
		logic [Q_W-1:0] q;
	} mdu_rsp_t;

endpackage

FILE: design/contingency_chisq_statistic_top.sv
// Top level of the Pearson chi-square contingency table statistic.
// Loading takes one cell per cycle; busy stays low between cells of a table.
// After the last cell, each cell runs through one shared multiply/divide unit. Multiplies
// handle one multiplier bit per cycle and the divide takes 49 steps; busy is high meanwhile.
// In S_DONE the result is registered and then shown on done; it cannot be stalled.
// Reset clears totals and counters and sets rows and columns to 2; the stores keep no reset.
`timescale 1ns / 1ps

module contingency_chisq_statistic_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [15:0]                      cell_count,
	input  logic [24:0]                      cell_null_prob,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ccs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ccs_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                             done,
	output logic [47:0]                      statistic,
	output logic [7:0]                       degrees_of_freedom,
	output logic                             saturated
);
	import ccs_pkg::*;

	typedef enum logic [13:0] {
		S_LOAD = 14'b00000000000001,
		S_READ = 14'b00000000000010,
		S_MUL1 = 14'b00000000000100,
		S_W1   = 14'b00000000001000,
		S_MUL2 = 14'b00000000010000,
		S_W2   = 14'b00000000100000,
		S_DIFF = 14'b00000001000000,
		S_SQR  = 14'b00000010000000,
		S_W3   = 14'b00000100000000,
		S_MUL4 = 14'b00001000000000,
		S_W4   = 14'b00010000000000,
		S_DIV  = 14'b00100000000000,
		S_W5   = 14'b01000000000000,
		S_DONE = 14'b10000000000000
	} state_t;

	state_t state_q;

	logic        null_q;
	logic [4:0]  rows_q, cols_q;
	logic [4:0]  rows_eff, cols_eff;
	logic [RW-1:0] rows_last, r_q;
	logic [CW-1:0] cols_last, c_q;
	logic        last_c, last_cell;

	logic [23:0] row_tot_q [MAX_ROWS];
	logic [23:0] col_tot_q [MAX_COLS];
	logic [23:0] grand_q;
	logic [23:0] grand_nx;

	logic [15:0] cell_mem [2**(RW+CW)];
	logic [24:0] prob_mem [2**(RW+CW)];
	logic [15:0] rd_cell_q;
	logic [24:0] rd_prob_q;

	logic [Q_W-1:0] x1_q;
	logic [39:0]    a_q;
	logic [Q_W-1:0] d_q;
	logic [P_W-1:0] num_q;
	logic [D_W-1:0] den_q;
	logic [47:0]    sum_q;
	logic           sat_q;
	logic [48:0]    acc_w;
	logic [9:0]     rc_prod;
	logic [9:0]     dof_w;

	logic done_q;
	logic [47:0] statistic_q;
	logic [7:0]  dof_q;
	logic        saturated_q;

	logic accept, cfg_we;

	mdu_cmd_t cmd;
	mdu_rsp_t rsp;

	ccs_muldiv u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	// Out-of-range row and column counts are pulled into 1..MAX.
	always_comb begin
		if (rows_q == '0) rows_eff = 5'd1;
		else if (int'(rows_q) > MAX_ROWS) rows_eff = 5'(MAX_ROWS);
		else rows_eff = rows_q;
		if (cols_q == '0) cols_eff = 5'd1;
		else if (int'(cols_q) > MAX_COLS) cols_eff = 5'(MAX_COLS);
		else cols_eff = cols_q;
		rows_last = RW'(rows_eff - 5'd1);
		cols_last = CW'(cols_eff - 5'd1);
		last_c = (c_q == cols_last);
		last_cell = last_c && (r_q == rows_last);
		rc_prod = 10'(rows_eff) * 10'(cols_eff);
		dof_w = null_q ? (rc_prod - 10'd1) : (10'(rows_eff - 5'd1) * 10'(cols_eff - 5'd1));
		grand_nx = grand_q + 24'(cell_count);
		acc_w = {1'b0, sum_q} + {1'b0, rsp.q[47:0]};
	end

	// A cell transfer takes precedence, so configuration is ready only without one.
	assign busy = (state_q != S_LOAD);
	assign cfg_ready = !busy && !start;
	assign accept = start && !busy;
	assign cfg_we = cfg_valid && cfg_ready;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_MUL1: begin
				cmd.start = 1'b1;
				if (null_q) begin
					cmd.opa = P_W'(grand_q);
					cmd.opb = D_W'(rd_prob_q);
				end else begin
					cmd.opa = P_W'(row_tot_q[r_q]);
					cmd.opb = D_W'(col_tot_q[c_q]);
				end
			end
			S_MUL2: begin
				cmd.start = 1'b1;
				cmd.opa = P_W'(grand_q);
				cmd.opb = D_W'(rd_cell_q);
			end
			S_SQR: begin
				cmd.start = 1'b1;
				cmd.opa = P_W'(d_q);
				cmd.opb = D_W'(d_q);
			end
			S_MUL4: begin
				cmd.start = 1'b1;
				cmd.opa = P_W'(x1_q);
				cmd.opb = D_W'(grand_q);
			end
			S_DIV: begin
				cmd.start = 1'b1;
				cmd.is_div = 1'b1;
				cmd.opa = num_q;
				cmd.opb = den_q;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cell_mem[{r_q, c_q}] <= cell_count;
			prob_mem[{r_q, c_q}] <= cell_null_prob;
		end
		rd_cell_q <= cell_mem[{r_q, c_q}];
		rd_prob_q <= prob_mem[{r_q, c_q}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			null_q <= 1'b0;
			rows_q <= 5'd2;
			cols_q <= 5'd2;
			r_q <= '0;
			c_q <= '0;
			grand_q <= '0;
			sat_q <= 1'b0;
			done_q <= 1'b0;
			for (int i = 0; i < MAX_ROWS; i++) row_tot_q[i] <= '0;
			for (int j = 0; j < MAX_COLS; j++) col_tot_q[j] <= '0;
		end else begin
			done_q <= (state_q == S_DONE);
			unique case (state_q)
				S_LOAD: begin
					if (accept) begin
						row_tot_q[r_q] <= row_tot_q[r_q] + 24'(cell_count);
						col_tot_q[c_q] <= col_tot_q[c_q] + 24'(cell_count);
						grand_q <= grand_nx;
						if (last_cell) begin
							r_q <= '0;
							c_q <= '0;
							sat_q <= 1'b0;
							// An empty table goes straight to a zero result.
							state_q <= (grand_nx == '0) ? S_DONE : S_READ;
						end else if (last_c) begin
							c_q <= '0;
							r_q <= r_q + 1'b1;
						end else begin
							c_q <= c_q + 1'b1;
						end
					end else if (cfg_we) begin
						case (cfg_index)
							CFG_NULL: null_q <= cfg_data[0];
							CFG_ROWS: rows_q <= cfg_data;
							CFG_COLS: cols_q <= cfg_data;
							default: ;
						endcase
						// A write to a known register restarts loading of the table.
						if (cfg_index == CFG_NULL || cfg_index == CFG_ROWS ||
						    cfg_index == CFG_COLS) begin
							r_q <= '0;
							c_q <= '0;
							grand_q <= '0;
							for (int i = 0; i < MAX_ROWS; i++) row_tot_q[i] <= '0;
							for (int j = 0; j < MAX_COLS; j++) col_tot_q[j] <= '0;
						end
					end
				end
				S_READ: state_q <= S_MUL1;
				S_MUL1: state_q <= S_W1;
				S_W1: begin
					if (rsp.done) begin
						// A cell whose expected count is zero contributes nothing.
						if (rsp.p == '0) begin
							if (last_cell) begin
								state_q <= S_DONE;
							end else begin
								state_q <= S_READ;
								if (last_c) begin
									c_q <= '0;
									r_q <= r_q + 1'b1;
								end else begin
									c_q <= c_q + 1'b1;
								end
							end
						end else begin
							state_q <= null_q ? S_DIFF : S_MUL2;
						end
					end
				end
				S_MUL2: state_q <= S_W2;
				S_W2: if (rsp.done) state_q <= S_DIFF;
				S_DIFF: state_q <= S_SQR;
				S_SQR: state_q <= S_W3;
				S_W3: if (rsp.done) state_q <= null_q ? S_DIV : S_MUL4;
				S_MUL4: state_q <= S_W4;
				S_W4: if (rsp.done) state_q <= S_DIV;
				S_DIV: state_q <= S_W5;
				S_W5: begin
					if (rsp.done) begin
						if (rsp.q[Q_W-1] || acc_w[48]) sat_q <= 1'b1;
						if (last_cell) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_READ;
							if (last_c) begin
								c_q <= '0;
								r_q <= r_q + 1'b1;
							end else begin
								c_q <= c_q + 1'b1;
							end
						end
					end
				end
				S_DONE: begin
					r_q <= '0;
					c_q <= '0;
					grand_q <= '0;
					for (int i = 0; i < MAX_ROWS; i++) row_tot_q[i] <= '0;
					for (int j = 0; j < MAX_COLS; j++) col_tot_q[j] <= '0;
					state_q <= S_LOAD;
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_LOAD && accept && last_cell) begin
			sum_q <= '0;
		end
		if (state_q == S_W1 && rsp.done) begin
			x1_q <= rsp.p[Q_W-1:0];
			a_q <= {rd_cell_q, 24'd0};
		end
		if (state_q == S_W2 && rsp.done) begin
			a_q <= rsp.p[39:0];
		end
		if (state_q == S_DIFF) begin
			d_q <= (Q_W'(a_q) > x1_q) ? (Q_W'(a_q) - x1_q) : (x1_q - Q_W'(a_q));
		end
		if (state_q == S_W3 && rsp.done) begin
			// Margin mode carries the 16 fraction bits in the numerator.
			num_q <= null_q ? rsp.p : {rsp.p[P_W-17:0], 16'd0};
			den_q <= {(D_W-Q_W-8)'(0), x1_q, 8'd0};
		end
		if (state_q == S_W4 && rsp.done) begin
			den_q <= rsp.p[D_W-1:0];
		end
		if (state_q == S_W5 && rsp.done && !rsp.q[Q_W-1]) begin
			sum_q <= acc_w[47:0];
		end
		if (state_q == S_DONE) begin
			statistic_q <= sat_q ? '1 : sum_q;
			saturated_q <= sat_q;
			dof_q <= dof_w[7:0];
		end
	end

	assign done = done_q;
	assign statistic = statistic_q;
	assign degrees_of_freedom = dof_q;
	assign saturated = saturated_q;

endmodule

FILE: design/ccs_muldiv.sv
// Iterative shift-add multiplier and restoring divider around one shared adder.
`timescale 1ns / 1ps

module ccs_muldiv (
	input  logic              clk,
	input  logic              arst_n,
	input  ccs_pkg::mdu_cmd_t cmd,
	output ccs_pkg::mdu_rsp_t rsp
);
	import ccs_pkg::*;

	logic             busy_q;
	logic             div_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [P_W-1:0]   p_q;
	logic [M_W-1:0]   m_q;
	logic [Q_W-1:0]   b_q;

	logic [M_W-1:0] op2;
	logic [M_W:0]   sum_w;
	logic           ge;

	// In divide mode the adder subtracts, and its carry out says the remainder covers M.
	always_comb begin
		op2 = div_q ? ~m_q : m_q;
		sum_w = {1'b0, (M_W)'(p_q)} + {1'b0, op2} + (M_W+1)'(div_q);
		ge = sum_w[M_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			div_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= !cmd.start && busy_q && (div_q ? (cnt_q == '0) : (b_q == '0));
			if (cmd.start) begin
				busy_q <= 1'b1;
				div_q <= cmd.is_div;
				cnt_q <= CNT_W'(Q_W - 1);
			end else if (busy_q) begin
				if (div_q) begin
					if (cnt_q == '0) begin
						busy_q <= 1'b0;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end else if (b_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			if (cmd.is_div) begin
				p_q <= cmd.opa;
				m_q <= {cmd.opb, (Q_W-1)'(0)};
				b_q <= '0;
			end else begin
				p_q <= '0;
				m_q <= (M_W)'(cmd.opa);
				b_q <= cmd.opb[Q_W-1:0];
			end
		end else if (busy_q) begin
			if (div_q) begin
				if (ge) begin
					p_q <= sum_w[P_W-1:0];
				end
				m_q <= m_q >> 1;
				b_q <= {b_q[Q_W-2:0], ge};
			end else if (b_q != '0) begin
				if (b_q[0]) begin
					p_q <= sum_w[P_W-1:0];
				end
				m_q <= m_q << 1;
				b_q <= b_q >> 1;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.p = p_q;
	assign rsp.q = b_q;

endmodule

FILE: tb/sv/contingency_chisq_statistic_top_test.sv
// Testbench for the chi-square contingency table block: cell stimulus, scoreboard and checks.
`timescale 1ns / 1ps

module contingency_chisq_statistic_top_test;
	import ccs_pkg::*;

	typedef struct {
		logic [47:0] stat;
		logic [7:0]  dof;
		logic        sat;
	} chisq_result_t;

	localparam logic [63:0] STAT_MAX = 64'hFFFF_FFFF_FFFF;
	localparam int WATCHDOG_LIMIT = 250000;
	localparam int ITEM_TARGET = 1800;

	class chisq_scoreboard;
		bit            null_mode;
		bit [4:0]      rows_reg;
		bit [4:0]      cols_reg;
		bit [15:0]     counts [MAX_ROWS*MAX_COLS];
		bit [24:0]     probs [MAX_ROWS*MAX_COLS];
		bit [23:0]     row_sum [MAX_ROWS];
		bit [23:0]     col_sum [MAX_COLS];
		bit [23:0]     grand;
		int            loaded;
		chisq_result_t pending_stats [$];
		int            errors;

		function new();
			null_mode = 0;
			rows_reg = 2;
			cols_reg = 2;
			errors = 0;
			clear_totals();
		endfunction

		function int eff_size(bit [4:0] v, int max_v);
			if (v == 0)
				return 1;
			return (v > max_v) ? max_v : v;
		endfunction

		function void clear_totals();
			foreach (row_sum[i]) row_sum[i] = 0;
			foreach (col_sum[i]) col_sum[i] = 0;
			grand = 0;
			loaded = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_NULL: null_mode = val[0];
				CFG_ROWS: rows_reg = val;
				CFG_COLS: cols_reg = val;
				default: return;
			endcase
			clear_totals();
		endfunction

		function void note_cell(logic [15:0] cnt, logic [24:0] prob);
			int rows, cols, total;
			rows = eff_size(rows_reg, MAX_ROWS);
			cols = eff_size(cols_reg, MAX_COLS);
			total = rows * cols;
			if (loaded >= total)
				clear_totals();
			counts[loaded] = cnt;
			probs[loaded] = prob;
			row_sum[loaded / cols] += cnt;
			col_sum[loaded % cols] += cnt;
			grand += cnt;
			loaded++;
			if (loaded == total) begin
				table_chisq(rows, cols);
				clear_totals();
			end
		endfunction

		// Sums the exact per-cell terms of the finished table and queues the result.
		function void table_chisq(int rows, int cols);
			logic [63:0]  n, o, rc, a, d, e, sum;
			logic [127:0] q;
			bit           sat;
			chisq_result_t res;
			n = grand;
			sum = 0;
			sat = 0;
			if (n != 0) begin
				for (int i = 0; i < rows * cols; i++) begin
					o = counts[i];
					if (null_mode) begin
						e = n * probs[i];
						if (e == 0)
							continue;
						a = o << 24;
						d = (a > e) ? a - e : e - a;
						q = ({64'd0, d} * {64'd0, d}) / ({64'd0, e} << 8);
					end else begin
						rc = 64'(row_sum[i / cols]) * 64'(col_sum[i % cols]);
						if (rc == 0)
							continue;
						a = o * n;
						d = (a > rc) ? a - rc : rc - a;
						q = (({64'd0, d} * {64'd0, d}) << 16) / ({64'd0, n} * {64'd0, rc});
					end
					if (q > {64'd0, STAT_MAX}) begin
						sat = 1;
						continue;
					end
					sum += q[63:0];
					if (sum > STAT_MAX)
						sat = 1;
				end
			end
			res.stat = sat ? STAT_MAX[47:0] : sum[47:0];
			res.dof = null_mode ? 8'(rows * cols - 1) : 8'((rows - 1) * (cols - 1));
			res.sat = sat;
			pending_stats.push_back(res);
		endfunction

		function void check(logic [47:0] stat, logic [7:0] dof, logic sat);
			chisq_result_t want;
			if (pending_stats.size() == 0) begin
				$error("result with no table pending: statistic %h", stat);
				errors++;
				return;
			end
			want = pending_stats.pop_front();
			if (stat !== want.stat) begin
				$error("statistic: expected %h, got %h", want.stat, stat);
				errors++;
			end
			if (dof !== want.dof) begin
				$error("degrees_of_freedom: expected %0d, got %0d", want.dof, dof);
				errors++;
			end
			if (sat !== want.sat) begin
				$error("saturated: expected %0d, got %0d", want.sat, sat);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 0;
	logic                  arst_n = 0;
	logic                  start = 0;
	logic                  busy;
	logic [15:0]           cell_count = 0;
	logic [24:0]           cell_null_prob = 0;
	logic                  cfg_valid = 0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_NULL;
	logic [CFG_DATA_W-1:0] cfg_data = 0;
	logic                  done;
	logic [47:0]           statistic;
	logic [7:0]            degrees_of_freedom;
	logic                  saturated;

	chisq_scoreboard sb = new();
	int idle_pct = 0;
	int cells_sent = 0;
	int quiet_cycles = 0;

	contingency_chisq_statistic_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cell_count(cell_count),
		.cell_null_prob(cell_null_prob),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.statistic(statistic),
		.degrees_of_freedom(degrees_of_freedom),
		.saturated(saturated)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check(statistic, degrees_of_freedom, saturated);
	end

	// Any transfer on a port counts as progress.
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_cell(logic [15:0] cnt, logic [24:0] prob);
		int gap;
		start <= 1;
		cell_count <= cnt;
		cell_null_prob <= prob;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_cell(cnt, prob);
		cells_sent++;
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(posedge clk);
		end
	endtask

	// Registers change only with the block idle: no table in flight and no result owed.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		start <= 0;
		while (sb.pending_stats.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.write_reg(idx, val);
		cfg_valid <= 0;
	endtask

	task automatic set_table(bit null_mode, logic [4:0] rows, logic [4:0] cols);
		write_reg(CFG_NULL, {4'd0, null_mode});
		write_reg(CFG_ROWS, rows);
		write_reg(CFG_COLS, cols);
	endtask

	function automatic logic [15:0] rand_count();
		case ($urandom_range(3))
			0: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
			1: return 16'($urandom_range(15));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [24:0] rand_prob();
		case ($urandom_range(4))
			0: return 25'h1000000;
			1: return $urandom_range(1) ? 25'd0 : 25'h1FFFFFF;
			2: return 25'($urandom_range(1 << 20));
			default: return 25'($urandom);
		endcase
	endfunction

	function automatic logic [4:0] rand_size(inout int big_left);
		logic [4:0] v;
		if ($urandom_range(7) == 0) begin
			case ($urandom_range(3))
				0: v = 0;
				1: v = 17;
				2: v = 31;
				default: v = 16;
			endcase
		end else begin
			v = 5'($urandom_range(1, 4));
		end
		if (v > 4 && big_left <= 0)
			v = 5'($urandom_range(1, 4));
		else if (v > 4)
			big_left--;
		return v;
	endfunction

	initial begin
		int rows, cols, tables, part, big_left, phase;
		logic [4:0] rsel, csel;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Reset setting, 2x2 from the margins.
		repeat (4) send_cell(16'd0, 25'd0);
		repeat (4) send_cell(16'hFFFF, 25'h1FFFFFF);
		send_cell(16'hFFFF, 0); send_cell(0, 0); send_cell(0, 0); send_cell(16'hFFFF, 0);
		send_cell(1, 0); send_cell(0, 0); send_cell(0, 0); send_cell(0, 0);
		// A partial table, then a write that restarts loading.
		send_cell(16'h1234, 25'h0ABCDEF);
		// Null mode on a 1x2 table: a tiny probability saturates, a zero one is skipped.
		set_table(1, 1, 2);
		send_cell(16'hFFFF, 25'd1); send_cell(16'hFFFF, 25'd0);
		send_cell(16'd0, 25'h1000000); send_cell(16'd5, 25'h1FFFFFF);

		big_left = 4;
		phase = 0;
		while (cells_sent < ITEM_TARGET) begin
			rsel = rand_size(big_left);
			csel = rand_size(big_left);
			set_table(1'($urandom_range(1)), rsel, csel);
			rows = sb.eff_size(rsel, MAX_ROWS);
			cols = sb.eff_size(csel, MAX_COLS);
			case (phase % 4)
				0: idle_pct = 0;
				1: idle_pct = 66;
				2: idle_pct = 25;
				default: idle_pct = 66;
			endcase
			phase++;
			tables = (rows * cols > 64) ? 1 : $urandom_range(1, 5);
			repeat (tables)
				repeat (rows * cols) send_cell(rand_count(), rand_prob());
			if ($urandom_range(5) == 0) begin
				part = $urandom_range(rows * cols - 1);
				repeat (part) send_cell(rand_count(), rand_prob());
			end
		end

		start <= 0;
		while (sb.pending_stats.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.pending_stats.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: contingency_chisq_statistic_top.f
design/ccs_pkg.sv
design/ccs_muldiv.sv
design/contingency_chisq_statistic_top.sv
tb/sv/contingency_chisq_statistic_top_test.sv
